FILE: rtl/serialized_op_queue_with_done_merge_core_assert.svh
// Assertion macros for the serialized operation queue core.
// Used by the top level; relies on i_clk and i_rst_n being in scope.
`ifndef SERIALIZED_OP_QUEUE_WITH_DONE_MERGE_CORE_ASSERT_SVH
`define SERIALIZED_OP_QUEUE_WITH_DONE_MERGE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SOQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/soq_pkg.sv
// Shared types, constants and helpers for the serialized operation queue.
// No dependencies; imported by the core module.
package soq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [TAG_BITS-1:0] t_tag;
    typedef logic [PTR_W-1:0]    t_ptr;
    typedef logic [CNT_W-1:0]    t_cnt;

    // Input function codes.
    localparam logic [1:0] F_ENQ  = 2'd0;
    localparam logic [1:0] F_MARK = 2'd1;
    localparam logic [1:0] F_DONE = 2'd2;

    // Result kinds.
    localparam logic [1:0] K_ACK    = 2'd0;
    localparam logic [1:0] K_START  = 2'd1;
    localparam logic [1:0] K_NOTICE = 2'd2;

    // Acknowledgement status codes.
    localparam logic [1:0] S_STARTED = 2'd0;
    localparam logic [1:0] S_QUEUED  = 2'd1;
    localparam logic [1:0] S_REFUSED = 2'd2;
    localparam logic [1:0] S_FULL    = 2'd3;

    // One queue entry as held in the entry memory.
    typedef struct packed {
        t_tag op;
        t_tag done;
        logic has_done;
        logic blocks;
    } t_entry;

    // One result transaction.
    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        t_tag       op;
        t_tag       done;
        logic       last;
    } t_result;

    // Circular pointer increment for any depth.
    function automatic t_ptr ptr_next(t_ptr p);
        return (p == t_ptr'(QUEUE_DEPTH - 1)) ? '0 : p + t_ptr'(1);
    endfunction

endpackage

FILE: rtl/serialized_op_queue_with_done_merge_core.sv
// Results leave one per cycle while i_stall is low, through a single output register; one
// emitted as an input is accepted shows on o_valid in the cycle after. Enqueue and block mark
// are handled in ST_IDLE. Op done gives the current notice, if any; then ST_EVAL, while output
// is free, pops a head entry per cycle: merged ones give notices until one is started or none is left.
// Reset (synchronous, active low) clears pointers, count, busy, pending mark and the
// current notice; the entry memory is not cleared and is only read where it was written.
`include "serialized_op_queue_with_done_merge_core_assert.svh"

module serialized_op_queue_with_done_merge_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel.
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  soq_pkg::t_tag      i_op_tag,
    input  soq_pkg::t_tag      i_done_tag,
    input  logic               i_has_done,
    input  logic               i_no_wait,
    // Output channel.
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic [1:0]         o_status,
    output soq_pkg::t_tag      o_op_out,
    output soq_pkg::t_tag      o_done_out,
    output logic               o_last
);
    import soq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } t_state;

    t_state  r_state, n_state;
    t_ptr    r_head, n_head;
    t_ptr    r_tail, n_tail;
    t_cnt    r_count, n_count;
    logic    r_busy, n_busy;
    logic    r_cur_valid, n_cur_valid;
    t_tag    r_cur_tag, n_cur_tag;
    logic    r_block_pend, n_block_pend;
    logic    r_out_valid, n_out_valid;
    t_result r_out, n_out;

    // Entry memory with a registered read port.
    t_entry  mem [QUEUE_DEPTH];
    t_entry  r_rd;
    logic    wr_en;
    t_entry  wr_data;

    logic    out_free;
    logic    accept;
    logic    em_valid;
    t_result em_res;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !(r_state == ST_IDLE && out_free);
    assign accept   = i_valid && !o_stall;

    // Sequencer: decode accepted input, then walk the head one entry a cycle unless stalled.
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_busy       = r_busy;
        n_cur_valid  = r_cur_valid;
        n_cur_tag    = r_cur_tag;
        n_block_pend = r_block_pend;
        wr_en        = 1'b0;
        wr_data      = '0;
        em_valid     = 1'b0;
        em_res       = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_func)
                        F_ENQ: begin
                            em_valid      = 1'b1;
                            em_res.kind   = K_ACK;
                            em_res.op     = i_op_tag;
                            em_res.last   = 1'b1;
                            if (!r_busy) begin
                                em_res.status = S_STARTED;
                                n_busy        = 1'b1;
                                n_block_pend  = 1'b0;
                                n_cur_valid   = i_has_done;
                                n_cur_tag     = i_has_done ? i_done_tag : '0;
                            end else if (i_no_wait && !i_has_done) begin
                                em_res.status = S_REFUSED;
                            end else if (r_count >= t_cnt'(QUEUE_DEPTH)) begin
                                em_res.status = S_FULL;
                            end else begin
                                em_res.status    = S_QUEUED;
                                wr_en            = 1'b1;
                                wr_data.op       = i_op_tag;
                                wr_data.done     = i_has_done ? i_done_tag : '0;
                                wr_data.has_done = i_has_done;
                                wr_data.blocks   = i_has_done ? r_block_pend : 1'b1;
                                n_tail           = ptr_next(r_tail);
                                n_count          = r_count + t_cnt'(1);
                                n_block_pend     = 1'b0;
                            end
                        end
                        F_MARK: begin
                            n_block_pend = 1'b1;
                        end
                        F_DONE: begin
                            if (r_busy) begin
                                if (r_cur_valid) begin
                                    em_valid    = 1'b1;
                                    em_res.kind = K_NOTICE;
                                    em_res.done = r_cur_tag;
                                    em_res.last = (r_count == '0);
                                end
                                n_cur_valid = 1'b0;
                                n_cur_tag   = '0;
                                if (r_count == '0) begin
                                    n_busy = 1'b0;
                                end else begin
                                    n_state = ST_EVAL;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EVAL: begin
                // r_rd holds the head entry, read in the previous cycle.
                if (out_free) begin
                    n_head  = ptr_next(r_head);
                    n_count = r_count - t_cnt'(1);
                    if (!r_rd.blocks) begin
                        // Merged entry: deliver its notice, never start it.
                        em_valid    = r_rd.has_done;
                        em_res.kind = K_NOTICE;
                        em_res.done = r_rd.done;
                        em_res.last = (r_count == t_cnt'(1));
                        if (r_count == t_cnt'(1)) begin
                            n_busy  = 1'b0;
                            n_state = ST_IDLE;
                        end
                    end else begin
                        em_valid    = 1'b1;
                        em_res.kind = K_START;
                        em_res.op   = r_rd.op;
                        em_res.last = 1'b1;
                        n_cur_valid = r_rd.has_done;
                        n_cur_tag   = r_rd.has_done ? r_rd.done : '0;
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Output register: drop a taken result, load a new one.
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        if (em_valid) begin
            n_out_valid = 1'b1;
            n_out       = em_res;
        end
    end

    // Control state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_busy       <= 1'b0;
            r_cur_valid  <= 1'b0;
            r_cur_tag    <= '0;
            r_block_pend <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_busy       <= n_busy;
            r_cur_valid  <= n_cur_valid;
            r_cur_tag    <= n_cur_tag;
            r_block_pend <= n_block_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Entry memory. The read port follows the next head every cycle, so the head entry is
    // fresh in the cycle after an op done is accepted. Writes happen only at the tail on an
    // enqueue, a separate transaction, so a write never races the read that is used.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_tail] <= wr_data;
        end
        r_rd <= mem[n_head];
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_out.kind;
    assign o_status   = r_out.status;
    assign o_op_out   = r_out.op;
    assign o_done_out = r_out.done;
    assign o_last     = r_out.last;

    // Checks on the sequencer and queue bookkeeping.
    `SOQ_ASSERT_NOW(a_idle_empty, !r_busy, (r_count == '0) && !r_cur_valid, "idle with queue state")
    `SOQ_ASSERT_NOW(a_count_max, 1'b1, r_count <= t_cnt'(QUEUE_DEPTH), "entry count overflow")
    `SOQ_ASSERT_NOW(a_merge_notice, (r_state == ST_EVAL) && out_free && !r_rd.blocks,
                    r_rd.has_done, "merged entry without notice")
    `SOQ_ASSERT_NEXT(a_done_drain, accept && (i_func == F_DONE) && r_busy && (r_count == '0),
                     !r_busy && (r_state == ST_IDLE), "op done on empty queue did not go idle")

endmodule
